// ----- rtl/gaussian_mixture_responsibility_top_assert.svh -----
// Assertion macros for the mixture responsibility block.
`ifndef GAUSSIAN_MIXTURE_RESPONSIBILITY_TOP_ASSERT_SVH
`define GAUSSIAN_MIXTURE_RESPONSIBILITY_TOP_ASSERT_SVH

// Check a property while out of reset.
`define GMR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property in every cycle, reset included.
`define GMR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ----- rtl/gmr_pkg.sv -----
// Shared constants and types of the mixture responsibility block.
`timescale 1ns / 1ps
package gmr_pkg;
   localparam int EXP_LAT  = 18;
   localparam int DIV_LAT  = 18;
   localparam int PIPE_LAT = EXP_LAT + DIV_LAT;
   localparam int ITER     = 5;
   localparam int QBITS    = 17;

   localparam logic [24:0] Q24_ONE   = 25'h100_0000;
   localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
   localparam logic [23:0] LN2_Q24   = 24'd11629080;
   localparam logic [16:0] HALF_Q16  = 17'd32768;

   // floor(v / k) for k = 5, 4, 3, 2, 1 on 24-bit v: (v * mul) >> shift
   localparam logic [25:0] RECIP_MUL [ITER] = '{26'd26843546, 26'd1, 26'd22369622, 26'd1, 26'd1};
   localparam logic [4:0]  RECIP_SH  [ITER] = '{5'd27, 5'd2, 5'd26, 5'd1, 5'd0};

   typedef enum logic [2:0] {
      CSR_MEAN_FIRST   = 3'd0,
      CSR_MEAN_SECOND  = 3'd1,
      CSR_SCALE_FIRST  = 3'd2,
      CSR_SCALE_SECOND = 3'd3,
      CSR_PEAK_FIRST   = 3'd4,
      CSR_PEAK_SECOND  = 3'd5,
      CSR_THRESHOLD    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [16:0] ownership;
      logic        valid_res;
   } div_result_type;
endpackage

// ----- rtl/gmr_density.sv -----
// Weighted Gaussian density pipeline for one mixture component.
`timescale 1ns / 1ps
module gmr_density (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] sample,
   input  logic [31:0] mean,
   input  logic [31:0] scale,
   input  logic [31:0] peak,
   output logic [31:0] density
);
   import gmr_pkg::*;

   logic [32:0] diff;
   logic [32:0] absd;
   logic [31:0] ad_ff;
   logic        z1_ff, z2_ff, z3_ff, z4_ff, z5_ff, z6_ff;
   logic [63:0] sq_ff;
   logic [63:0] ph_ff, pl_ff;
   logic [64:0] t_sum;
   logic [28:0] t_ff;
   logic [29:0] u_ff;
   logic [53:0] u_prod;
   logic [47:0] y_prod;
   logic [23:0] y6_ff;
   logic [5:0]  n6_ff;

   logic [48:0] ya_m_ff [ITER];
   logic [23:0] ya_y_ff [ITER];
   logic [5:0]  ya_n_ff [ITER];
   logic        ya_z_ff [ITER];
   logic [24:0] yb_a_ff [ITER];
   logic [23:0] yb_y_ff [ITER];
   logic [5:0]  yb_n_ff [ITER];
   logic        yb_z_ff [ITER];

   logic [24:0] e_in, e_ff;
   logic [56:0] p_prod;
   logic [31:0] p_ff;

   assign diff  = {sample[31], sample} - {mean[31], mean};
   assign absd  = diff[32] ? (33'd0 - diff) : diff;
   assign t_sum = {1'b0, ph_ff} + 65'(pl_ff[63:32]);
   assign u_prod = 54'(t_ff) * 54'(LOG2E_Q24);
   assign y_prod = 48'(u_ff[23:0]) * 48'(LN2_Q24);

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff <= absd[31:0];
         z1_ff <= (scale != 32'd0) && absd[32];
         sq_ff <= 64'(ad_ff) * 64'(ad_ff);
         z2_ff <= z1_ff;
         ph_ff <= 64'(sq_ff[63:32]) * 64'(scale);
         pl_ff <= 64'(sq_ff[31:0]) * 64'(scale);
         z3_ff <= z2_ff;
         t_ff  <= t_sum[28:0];
         z4_ff <= z3_ff || (t_sum[64:29] != 36'd0);
         u_ff  <= u_prod[53:24];
         z5_ff <= z4_ff;
         y6_ff <= y_prod[47:24];
         n6_ff <= u_ff[29:24];
         z6_ff <= z5_ff;
      end
   end

   for (genvar j = 0; j < ITER; j++) begin : g_iter
      logic [23:0] y_src;
      logic [24:0] a_src;
      logic [5:0]  n_src;
      logic        z_src;
      logic [49:0] q_prod;
      logic [23:0] q;

      if (j == 0) begin : g_first
         assign y_src = y6_ff;
         assign a_src = Q24_ONE;
         assign n_src = n6_ff;
         assign z_src = z6_ff;
      end else begin : g_next
         assign y_src = yb_y_ff[j-1];
         assign a_src = yb_a_ff[j-1];
         assign n_src = yb_n_ff[j-1];
         assign z_src = yb_z_ff[j-1];
      end

      assign q_prod = 50'(ya_m_ff[j][47:24]) * 50'(RECIP_MUL[j]);
      assign q      = 24'(q_prod >> RECIP_SH[j]);

      always_ff @(posedge clock) begin
         if (en) begin
            ya_m_ff[j] <= 49'(y_src) * 49'(a_src);
            ya_y_ff[j] <= y_src;
            ya_n_ff[j] <= n_src;
            ya_z_ff[j] <= z_src;
            yb_a_ff[j] <= Q24_ONE - 25'(q);
            yb_y_ff[j] <= ya_y_ff[j];
            yb_n_ff[j] <= ya_n_ff[j];
            yb_z_ff[j] <= ya_z_ff[j];
         end
      end
   end

   always_comb begin
      if (yb_z_ff[ITER-1] || (yb_n_ff[ITER-1] >= 6'd25)) begin
         e_in = 25'd0;
      end else begin
         e_in = yb_a_ff[ITER-1] >> yb_n_ff[ITER-1];
      end
   end

   assign p_prod = 57'(peak) * 57'(e_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         e_ff <= e_in;
         p_ff <= p_prod[55:24];
      end
   end

   assign density = p_ff;
endmodule

// ----- rtl/gmr_div.sv -----
// Pipelined restoring divider for the rounded second-component share.
`timescale 1ns / 1ps
module gmr_div (
   input  logic                    clock,
   input  logic                    en,
   input  logic [31:0]             p_first,
   input  logic [31:0]             p_second,
   output gmr_pkg::div_result_type result
);
   import gmr_pkg::*;

   logic [32:0] sum_in;
   logic [48:0] num_in;

   logic [48:0]      rem_ff  [QBITS+1];
   logic [32:0]      sum_ff  [QBITS+1];
   logic [QBITS-1:0] quo_ff  [QBITS+1];
   logic             zero_ff [QBITS+1];
   logic             vres_ff [QBITS+1];

   assign sum_in = {1'b0, p_first} + {1'b0, p_second};
   assign num_in = {1'b0, p_second, 16'd0} + 49'(sum_in[32:1]);

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num_in;
         sum_ff[0]  <= sum_in;
         quo_ff[0]  <= '0;
         zero_ff[0] <= (sum_in == 33'd0);
         vres_ff[0] <= (33'(p_first) <= 33'(Q24_ONE)) && (33'(p_second) <= 33'(Q24_ONE));
      end
   end

   for (genvar j = 0; j < QBITS; j++) begin : g_bit
      localparam int BIT = QBITS - 1 - j;
      logic [48:0] dsh;
      logic        take;

      assign dsh  = 49'(sum_ff[j]) << BIT;
      assign take = (rem_ff[j] >= dsh);

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]       <= take ? (rem_ff[j] - dsh) : rem_ff[j];
            quo_ff[j+1]       <= quo_ff[j] | (QBITS'(take) << BIT);
            sum_ff[j+1]       <= sum_ff[j];
            zero_ff[j+1]      <= zero_ff[j];
            vres_ff[j+1]      <= vres_ff[j];
         end
      end
   end

   assign result.ownership = zero_ff[QBITS] ? HALF_Q16 : quo_ff[QBITS];
   assign result.valid_res = vres_ff[QBITS];
endmodule

// ----- rtl/gaussian_mixture_responsibility_top.sv -----
// Top level of the two-component mixture responsibility block.
//
// Input stream req_*: one beat per sample, tdata is the Q16.16 sample, tlast marks the
// last sample of a batch. Output stream rsp_*: one beat per sample in the same order,
// tdata is the Q1.16 ownership of the second component, tuser holds the valid flag and
// the cluster bit, tlast copies the input tlast.
// Registers are to be written through csr_* only while no sample is in flight; the block
// itself does not enforce this. Throughput: one beat per cycle while the output does not
// stall. An input beat passes through the density pipeline (18 stages: square, scale,
// exponential with five series steps, peak weighting), the one-bit-per-stage divider
// (18 stages) and the output register.
// Reset clears all valid bits and loads the register defaults; pipeline data is not reset.
// When rsp_tready is low the output beat holds, one more beat is caught in a skid register,
// and then req_tready drops and the whole pipeline holds.
`timescale 1ns / 1ps
module gaussian_mixture_responsibility_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] sample
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [16:0] ownership, [23:17] zero
   output logic [1:0]  rsp_tuser,   // [0] valid_res, [1] second_cluster
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import gmr_pkg::*;

   logic [31:0] mean_first_ff, mean_second_ff;
   logic [31:0] scale_first_ff, scale_second_ff;
   logic [31:0] peak_first_ff, peak_second_ff;
   logic [16:0] threshold_ff;

   logic [PIPE_LAT-1:0] vld_ff;
   logic [PIPE_LAT-1:0] last_ff;
   logic                en;
   logic [31:0]         p_first, p_second;
   div_result_type      div_res;

   logic        pipe_valid;
   logic [19:0] pipe_beat;
   logic        out_valid_ff, skid_valid_ff;
   logic [19:0] out_beat_ff, skid_beat_ff;
   logic        out_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_first_ff   <= 32'd0;
         mean_second_ff  <= 32'd0;
         scale_first_ff  <= 32'd16777216;
         scale_second_ff <= 32'd16777216;
         peak_first_ff   <= 32'd8388608;
         peak_second_ff  <= 32'd8388608;
         threshold_ff    <= 17'd32768;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MEAN_FIRST:   mean_first_ff   <= csr_wdata;
            CSR_MEAN_SECOND:  mean_second_ff  <= csr_wdata;
            CSR_SCALE_FIRST:  scale_first_ff  <= csr_wdata;
            CSR_SCALE_SECOND: scale_second_ff <= csr_wdata;
            CSR_PEAK_FIRST:   peak_first_ff   <= csr_wdata;
            CSR_PEAK_SECOND:  peak_second_ff  <= csr_wdata;
            CSR_THRESHOLD:    threshold_ff    <= csr_wdata[16:0];
            default: begin
            end
         endcase
      end
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff <= {last_ff[PIPE_LAT-2:0], req_tlast};
      end
   end

   gmr_density u_first (
      .clock   (clock),
      .en      (en),
      .sample  (req_tdata),
      .mean    (mean_first_ff),
      .scale   (scale_first_ff),
      .peak    (peak_first_ff),
      .density (p_first)
   );

   gmr_density u_second (
      .clock   (clock),
      .en      (en),
      .sample  (req_tdata),
      .mean    (mean_second_ff),
      .scale   (scale_second_ff),
      .peak    (peak_second_ff),
      .density (p_second)
   );

   gmr_div u_div (
      .clock    (clock),
      .en       (en),
      .p_first  (p_first),
      .p_second (p_second),
      .result   (div_res)
   );

   assign pipe_valid = vld_ff[PIPE_LAT-1];
   assign pipe_beat  = {last_ff[PIPE_LAT-1], (div_res.ownership >= threshold_ff),
                        div_res.valid_res, div_res.ownership};
   assign out_take   = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_take) begin
         out_valid_ff  <= skid_valid_ff || pipe_valid;
         skid_valid_ff <= 1'b0;
      end else if (pipe_valid && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_take) begin
         out_beat_ff <= skid_valid_ff ? skid_beat_ff : pipe_beat;
      end else if (pipe_valid && en) begin
         skid_beat_ff <= pipe_beat;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_beat_ff[16:0]};
   assign rsp_tuser  = out_beat_ff[18:17];
   assign rsp_tlast  = out_beat_ff[19];
endmodule

// ----- rtl/gmr_checker.sv -----
// Port checker for the mixture responsibility block and its bind.
`timescale 1ns / 1ps
`include "gaussian_mixture_responsibility_top_assert.svh"
module gmr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   `GMR_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "output beat changed while stalled")
   `GMR_ASSERT(a_own_range, rsp_tvalid |-> rsp_tdata[23:0] <= 24'd65536, "ownership above one")
   `GMR_ASSERT(a_stall_cause, !req_tready |-> rsp_tvalid && $past(rsp_tvalid && !rsp_tready), "input stalled without a waiting output beat")
   `GMR_ASSERT_ALWAYS(a_reset_clear, $past(reset) |-> !rsp_tvalid && req_tready, "pipeline not cleared by reset")
endmodule

bind gaussian_mixture_responsibility_top gmr_checker u_gmr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
